/* design/lzwd_pkg.sv */
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared types and constants of the LZW code decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;

  localparam int AddrBits    = 12;
  localparam int DictDepth   = 1 << AddrBits;
  localparam int ChunkBytes  = 64;
  localparam int ChunkBits   = ChunkBytes * 8;
  localparam int RowBits     = AddrBits - 6;
  localparam int MaxCodeBits = 12;

  localparam logic [11:0] ClearCode   = 12'h100;
  localparam logic [11:0] StopCode    = 12'h101;
  localparam logic [12:0] BaseEntries = 13'd258;
  localparam logic [12:0] FullCount   = 13'd4096;
  localparam logic [3:0]  StartWidth  = 4'd9;
  localparam logic [11:0] MaxLength   = 12'd4095;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_STOP  = 2'd1,
    ST_LIMIT = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  typedef struct packed {
    logic [11:0] prefix;
    logic [7:0]  data_byte;
    logic [11:0] length;
  } entry_t;

  typedef struct packed {
    logic        pl_we;
    logic [11:0] pl_addr;
    logic [11:0] prefix;
    logic [11:0] length;
    logic        byte_we;
    logic [11:0] byte_addr;
    logic [7:0]  data_byte;
  } dict_wr_t;

endpackage

/* design/lzwd_dict.sv */
// ----------------------------------------------------------------------------
// lzwd_dict
// Dictionary store: prefix/length memory and byte memory, one read port with
// a registered read; codes below 258 read as the base entries.
// ----------------------------------------------------------------------------
module lzwd_dict (
  input  logic              clk,
  input  logic [11:0]       rd_addr,
  input  lzwd_pkg::dict_wr_t wr,
  output lzwd_pkg::entry_t  rd_entry
);

  logic [23:0] pl_mem [lzwd_pkg::DictDepth];
  logic [7:0]  byte_mem [lzwd_pkg::DictDepth];
  logic [23:0] pl_q;
  logic [7:0]  byte_q;
  logic [11:0] addr_q;

  always_ff @(posedge clk) begin
    if (wr.pl_we) begin
      pl_mem[wr.pl_addr] <= {wr.prefix, wr.length};
    end
    pl_q <= pl_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.byte_we) begin
      byte_mem[wr.byte_addr] <= wr.data_byte;
    end
    byte_q <= byte_mem[rd_addr];
    addr_q <= rd_addr;
  end

  always_comb begin
    if ({1'b0, addr_q} < lzwd_pkg::BaseEntries) begin
      rd_entry.prefix    = 12'd0;
      rd_entry.data_byte = addr_q[7:0];
      rd_entry.length    = 12'd1;
    end else begin
      rd_entry.prefix    = pl_q[23:12];
      rd_entry.data_byte = byte_q;
      rd_entry.length    = pl_q[11:0];
    end
  end

endmodule

/* design/lzwd_strbuf.sv */
// ----------------------------------------------------------------------------
// lzwd_strbuf
// String buffer: rows of 64 bytes, byte writes, one registered row read.
// ----------------------------------------------------------------------------
module lzwd_strbuf (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [lzwd_pkg::AddrBits-1:0]          wr_pos,
  input  logic [7:0]                             wr_byte,
  input  logic                                   rd_en,
  input  logic [lzwd_pkg::RowBits-1:0]           rd_row,
  output logic [lzwd_pkg::ChunkBits-1:0]         rd_data
);

  logic [lzwd_pkg::ChunkBits-1:0] mem [1 << lzwd_pkg::RowBits];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_pos[lzwd_pkg::AddrBits-1:6]][{wr_pos[5:0], 3'b000} +: 8] <= wr_byte;
    end
    if (rd_en) begin
      rd_data <= mem[rd_row];
    end
  end

endmodule

/* design/lzw_code_decoder_core.sv */
// ----------------------------------------------------------------------------
// lzw_code_decoder_core
// LZW decoder: one code in, its string out in 64-byte words, or one empty status word.
// ----------------------------------------------------------------------------
//  channel | signals                          | dir
//  in      | in_valid, in_ready, code         | in
//  out     | out_valid, out_ready, lane_0..7, | out
//          | byte_count, last, next_width,    |
//          | status                           |
//  cfg     | cfg_valid, cfg_ready, cfg_data   | in
//
// For a data code, the single dictionary read port walks the prefix chain
// twice, once for the first byte and once to fill the string buffer. Other
// codes go from idle straight to a status word.
// Reset clears control state only; no clearing pass over the memories.
// A stalled output word holds; while the last word of a string stalls, the next code is taken and waits.
// ----------------------------------------------------------------------------
module lzw_code_decoder_core #(
  parameter int MaxCodeBits = lzwd_pkg::MaxCodeBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] lane_0,
  output logic [63:0] lane_1,
  output logic [63:0] lane_2,
  output logic [63:0] lane_3,
  output logic [63:0] lane_4,
  output logic [63:0] lane_5,
  output logic [63:0] lane_6,
  output logic [63:0] lane_7,
  output logic [6:0]  byte_count,
  output logic        last,
  output logic [3:0]  next_width,
  output logic [1:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_FIND  = 8'b00000010,
    S_PATCH = 8'b00000100,
    S_ISSUE = 8'b00001000,
    S_BUILD = 8'b00010000,
    S_OPEN  = 8'b00100000,
    S_EMIT  = 8'b01000000,
    S_CTRL  = 8'b10000000
  } state_t;

  state_t                state;
  logic [11:0]           code_q;
  logic [11:0]           len_q;
  logic [7:0]            first_q;
  logic [11:0]           idx;
  logic                  first_rd;
  logic [12:0]           entry_count;
  logic [3:0]            code_width;
  logic [32:0]           bytes_emitted;
  logic                  finished;
  lzwd_pkg::status_t     finish_cause;
  lzwd_pkg::status_t     ctrl_status;
  logic [31:0]           byte_limit;
  logic [11:0]           remaining;
  logic [lzwd_pkg::RowBits-1:0] row;
  logic [lzwd_pkg::ChunkBits-1:0] out_data;

  logic [11:0]           rd_addr;
  lzwd_pkg::entry_t      ent;
  lzwd_pkg::dict_wr_t    dict_wr;
  logic                  sb_re;
  logic [lzwd_pkg::RowBits-1:0] sb_row;
  logic [lzwd_pkg::ChunkBits-1:0] sb_q;
  logic                  slot_free;
  logic [12:0]           pend;
  logic [12:0]           count_next;
  logic [6:0]            cnt;
  logic [lzwd_pkg::ChunkBits-1:0] chunk_masked;

  lzwd_dict u_dict (
    .clk      (clk),
    .rd_addr  (rd_addr),
    .wr       (dict_wr),
    .rd_entry (ent)
  );

  lzwd_strbuf u_strbuf (
    .clk     (clk),
    .wr_en   (state == S_BUILD),
    .wr_pos  (idx),
    .wr_byte (ent.data_byte),
    .rd_en   (sb_re),
    .rd_row  (sb_row),
    .rd_data (sb_q)
  );

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid || out_ready;
  assign pend      = entry_count - 13'd1;
  assign count_next = entry_count + {12'd0, (entry_count <= lzwd_pkg::FullCount)};
  assign cnt       = (remaining >= 12'd64) ? 7'd64 : remaining[6:0];

  always_comb begin
    for (int i = 0; i < lzwd_pkg::ChunkBytes; i++) begin
      chunk_masked[i*8 +: 8] = (7'(i) < cnt) ? sb_q[i*8 +: 8] : 8'd0;
    end
  end

  always_comb begin
    unique case (state)
      S_IDLE:  rd_addr = code;
      S_FIND:  rd_addr = ent.prefix;
      S_BUILD: rd_addr = ent.prefix;
      default: rd_addr = code_q;
    endcase
  end

  always_comb begin
    dict_wr.pl_we     = (state == S_OPEN) && (entry_count < lzwd_pkg::FullCount);
    dict_wr.pl_addr   = entry_count[11:0];
    dict_wr.prefix    = code_q;
    dict_wr.length    = (len_q < lzwd_pkg::MaxLength) ? len_q + 12'd1 : lzwd_pkg::MaxLength;
    dict_wr.byte_we   = (state == S_PATCH) && (pend >= lzwd_pkg::BaseEntries)
                        && (pend < lzwd_pkg::FullCount);
    dict_wr.byte_addr = pend[11:0];
    dict_wr.data_byte = first_q;
  end

  always_comb begin
    sb_re  = 1'b0;
    sb_row = row;
    if (state == S_OPEN) begin
      sb_re  = 1'b1;
      sb_row = '0;
    end else if (state == S_EMIT && slot_free) begin
      sb_re  = 1'b1;
      sb_row = row + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      entry_count   <= '0;
      code_width    <= lzwd_pkg::StartWidth;
      bytes_emitted <= '0;
      finished      <= 1'b0;
      finish_cause  <= lzwd_pkg::ST_OK;
      ctrl_status   <= lzwd_pkg::ST_OK;
      byte_limit    <= 32'hFFFF_FFFF;
      out_valid     <= 1'b0;
      first_rd      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        byte_limit <= cfg_data;
      end
      if (out_valid && out_ready && state != S_EMIT && state != S_CTRL) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            code_q <= code;
            state  <= S_CTRL;
            if (finished) begin
              ctrl_status <= finish_cause;
            end else if (bytes_emitted > {1'b0, byte_limit}) begin
              ctrl_status <= lzwd_pkg::ST_LIMIT;
            end else if (code == lzwd_pkg::ClearCode) begin
              entry_count <= lzwd_pkg::BaseEntries;
              code_width  <= lzwd_pkg::StartWidth;
              ctrl_status <= lzwd_pkg::ST_OK;
            end else if (code == lzwd_pkg::StopCode) begin
              finished     <= 1'b1;
              finish_cause <= lzwd_pkg::ST_STOP;
              ctrl_status  <= lzwd_pkg::ST_STOP;
            end else if ({1'b0, code} >= entry_count) begin
              finished     <= 1'b1;
              finish_cause <= lzwd_pkg::ST_BAD;
              ctrl_status  <= lzwd_pkg::ST_BAD;
            end else begin
              first_rd <= 1'b1;
              state    <= S_FIND;
            end
          end
        end
        S_FIND: begin
          // capture the string length from the code's own entry
          if (first_rd) begin
            len_q    <= (ent.length == 12'd0) ? 12'd1 : ent.length;
            first_rd <= 1'b0;
          end
          if (ent.length <= 12'd1) begin
            first_q <= ent.data_byte;
            state   <= S_PATCH;
          end
        end
        S_PATCH: begin
          state <= S_ISSUE;
        end
        S_ISSUE: begin
          idx   <= len_q - 12'd1;
          state <= S_BUILD;
        end
        S_BUILD: begin
          // fill the string from its last byte backward
          if (idx == 12'd0) begin
            state <= S_OPEN;
          end else begin
            idx <= idx - 12'd1;
          end
        end
        S_OPEN: begin
          entry_count <= count_next;
          if (code_width < 4'(MaxCodeBits)
              && count_next > (13'd1 << code_width)) begin
            code_width <= code_width + 4'd1;
          end
          bytes_emitted <= bytes_emitted + {21'd0, len_q};
          remaining     <= len_q;
          row           <= '0;
          state         <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid  <= 1'b1;
            out_data   <= chunk_masked;
            byte_count <= cnt;
            last       <= (remaining <= 12'd64);
            next_width <= code_width;
            status     <= lzwd_pkg::ST_OK;
            remaining  <= remaining - {5'd0, cnt};
            row        <= row + 1'b1;
            if (remaining <= 12'd64) begin
              state <= S_IDLE;
            end
          end
        end
        S_CTRL: begin
          if (slot_free) begin
            out_valid  <= 1'b1;
            out_data   <= '0;
            byte_count <= 7'd0;
            last       <= 1'b1;
            next_width <= code_width;
            status     <= ctrl_status;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign lane_0 = out_data[0*64 +: 64];
  assign lane_1 = out_data[1*64 +: 64];
  assign lane_2 = out_data[2*64 +: 64];
  assign lane_3 = out_data[3*64 +: 64];
  assign lane_4 = out_data[4*64 +: 64];
  assign lane_5 = out_data[5*64 +: 64];
  assign lane_6 = out_data[6*64 +: 64];
  assign lane_7 = out_data[7*64 +: 64];

  a_width_range: assert property (@(posedge clk) disable iff (rst)
    code_width >= lzwd_pkg::StartWidth && code_width <= 4'(MaxCodeBits))
    else $error("code width out of range");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= lzwd_pkg::FullCount + 13'd1)
    else $error("entry count past full dictionary");

  a_chunk_size: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> byte_count <= 7'd64)
    else $error("chunk larger than 64 bytes");

  a_ctrl_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != lzwd_pkg::ST_OK |-> byte_count == 7'd0 && last)
    else $error("error result carries data");

  a_finished_sticks: assert property (@(posedge clk) disable iff (rst)
    finished |=> finished)
    else $error("finished flag dropped");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives LZW codes into lzw_code_decoder_core under random idle and stall
// bursts. A built-in model of the dictionary predicts every output word, and
// each word is checked field by field. The test covers limit changes, a long
// self-referencing chain and a final stop or bad code.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CycleLimit = 2_000_000;
  localparam int DrainCycles = 60;

  typedef struct {
    logic [511:0]      data;
    logic [6:0]        count;
    logic              last;
    logic [3:0]        width;
    lzwd_pkg::status_t status;
  } chunk_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [11:0] code = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [63:0] lane_0, lane_1, lane_2, lane_3, lane_4, lane_5, lane_6, lane_7;
  logic [6:0]  byte_count;
  logic        last;
  logic [3:0]  next_width;
  logic [1:0]  status;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  lzw_code_decoder_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .code(code),
    .out_valid(out_valid), .out_ready(out_ready),
    .lane_0(lane_0), .lane_1(lane_1), .lane_2(lane_2), .lane_3(lane_3),
    .lane_4(lane_4), .lane_5(lane_5), .lane_6(lane_6), .lane_7(lane_7),
    .byte_count(byte_count), .last(last), .next_width(next_width),
    .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // dictionary model
  logic [11:0] dict_prefix [lzwd_pkg::DictDepth];
  logic [7:0]  dict_byte   [lzwd_pkg::DictDepth];
  logic [11:0] dict_len    [lzwd_pkg::DictDepth];
  logic [7:0]  str_bytes   [lzwd_pkg::DictDepth];
  int unsigned dict_count = 0;
  int unsigned cur_width = 9;
  longint unsigned bytes_out = 0;
  bit          done_flag = 0;
  lzwd_pkg::status_t done_cause = lzwd_pkg::ST_OK;
  logic [31:0] byte_limit = 32'hFFFF_FFFF;

  chunk_t      chunk_q[$];
  logic [11:0] code_q[$];
  int          errors = 0;
  int          cycles = 0;
  bit          calm = 0;
  int          in_gap = 0;
  int          out_stall = 0;
  bit          cfg_go = 0;
  logic [31:0] cfg_value = '0;
  int          cfg_acks = 0;
  int unsigned gen_count = 0;

  initial begin
    for (int i = 0; i < lzwd_pkg::DictDepth; i++) begin
      dict_prefix[i] = '0;
      dict_byte[i] = '0;
      dict_len[i] = '0;
    end
  end

  function automatic void push_control(lzwd_pkg::status_t st);
    chunk_t r;
    r.data = '0;
    r.count = '0;
    r.last = 1'b1;
    r.width = cur_width[3:0];
    r.status = st;
    chunk_q = {chunk_q, r};
  endfunction

  function automatic void decode_code(logic [11:0] c);
    int unsigned p, len, first, pend, nres, cnt, base;
    chunk_t r;
    if (done_flag) begin
      push_control(done_cause);
      return;
    end
    if (bytes_out > longint'(byte_limit)) begin
      push_control(lzwd_pkg::ST_LIMIT);
      return;
    end
    if (c == lzwd_pkg::ClearCode) begin
      for (int i = 0; i < 258; i++) begin
        dict_prefix[i] = '0;
        dict_byte[i] = i[7:0];
        dict_len[i] = 12'd1;
      end
      dict_count = 258;
      cur_width = 9;
      push_control(lzwd_pkg::ST_OK);
      return;
    end
    if (c == lzwd_pkg::StopCode || c >= dict_count) begin
      done_flag = 1;
      done_cause = (c == lzwd_pkg::StopCode) ? lzwd_pkg::ST_STOP : lzwd_pkg::ST_BAD;
      push_control(done_cause);
      return;
    end
    // walk to the base entry for the first byte
    p = c;
    while (dict_len[p] > 1) p = dict_prefix[p];
    first = dict_byte[p];
    pend = dict_count - 1;
    if (pend >= 258 && pend < lzwd_pkg::DictDepth) dict_byte[pend] = first[7:0];
    len = dict_len[c];
    if (len == 0) len = 1;
    p = c;
    for (int i = len; i > 0; i--) begin
      str_bytes[i - 1] = dict_byte[p];
      p = dict_prefix[p];
    end
    if (dict_count < lzwd_pkg::DictDepth) begin
      dict_prefix[dict_count] = c;
      dict_len[dict_count] = (len < 4095) ? 12'(len + 1) : 12'd4095;
    end
    if (dict_count <= lzwd_pkg::DictDepth) dict_count++;
    if (cur_width < lzwd_pkg::MaxCodeBits && dict_count > (1 << cur_width)) cur_width++;
    bytes_out += len;
    nres = (len + 63) / 64;
    for (int k = 0; k < nres; k++) begin
      base = k * 64;
      cnt = (len - base < 64) ? len - base : 64;
      r.data = '0;
      for (int i = 0; i < cnt; i++) r.data[8*i +: 8] = str_bytes[base + i];
      r.count = cnt[6:0];
      r.last = (k + 1 == nres);
      r.width = cur_width[3:0];
      r.status = lzwd_pkg::ST_OK;
      chunk_q = {chunk_q, r};
    end
  endfunction

  task automatic report(string field, logic [511:0] want, logic [511:0] got);
    $display("mismatch %s: expected %0h got %0h at %0t", field, want, got, $realtime);
    errors++;
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) decode_code(code);
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (code_q.size() > 0) begin
          code <= code_q.pop_front();
          in_valid <= 1'b1;
          if (!calm && $urandom_range(0, 6) == 0) in_gap = $urandom_range(1, 8);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    chunk_t e;
    logic [511:0] got;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {lane_7, lane_6, lane_5, lane_4, lane_3, lane_2, lane_1, lane_0};
        if (chunk_q.size() == 0) begin
          report("unexpected word", '0, got);
        end else begin
          e = chunk_q.pop_front();
          if (got !== e.data) report("data", e.data, got);
          if (byte_count !== e.count) report("byte_count", e.count, byte_count);
          if (last !== e.last) report("last", e.last, last);
          if (next_width !== e.width) report("next_width", e.width, next_width);
          if (status !== e.status) report("status", e.status, status);
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 6) == 0) out_stall = $urandom_range(1, 8);
      end
    end
  end

  // limit register writes
  always @(posedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      byte_limit = cfg_data;
      cfg_valid <= 1'b0;
      cfg_acks++;
    end else if (cfg_go && !cfg_valid) begin
      cfg_data <= cfg_value;
      cfg_valid <= 1'b1;
      cfg_go = 0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic add_code(logic [11:0] c);
    code_q = {code_q, c};
    if (c == lzwd_pkg::ClearCode) gen_count = 258;
    else if (c != lzwd_pkg::StopCode && c < gen_count && gen_count <= lzwd_pkg::DictDepth)
      gen_count++;
  endtask

  // mostly well-formed: literals, known entries, and the entry still pending
  function automatic logic [11:0] pick_code(int literal_pct);
    int unsigned top;
    top = (gen_count > lzwd_pkg::DictDepth) ? lzwd_pkg::DictDepth : gen_count;
    if ($urandom_range(0, 99) < literal_pct || top <= 258)
      return 12'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0 && gen_count > 258 && gen_count <= lzwd_pkg::DictDepth)
      return 12'(gen_count - 1);
    return 12'($urandom_range(258, top - 1));
  endfunction

  task automatic wait_idle();
    while (code_q.size() > 0 || in_valid || chunk_q.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_limit(logic [31:0] v);
    int acks;
    wait_idle();
    @(negedge clk);
    acks = cfg_acks;
    cfg_value = v;
    cfg_go = 1;
    while (cfg_acks == acks) @(negedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: base codes, pending entry, widths reset on clear
    add_code(lzwd_pkg::ClearCode);
    add_code(12'd0);
    add_code(12'd255);
    add_code(12'd258);
    add_code(12'(gen_count - 1));
    add_code(12'd65);
    add_code(12'd65);
    add_code(lzwd_pkg::ClearCode);
    add_code(12'd7);
    add_code(12'd7);
    add_code(12'(gen_count - 1));

    // limit at zero holds the next codes off; a limit equal to the bytes so far lets one more through
    write_limit(32'd0);
    add_code(12'd1);
    add_code(12'd258);
    write_limit(bytes_out[31:0]);
    add_code(12'd259);
    add_code(12'd2);
    add_code(12'd3);
    write_limit(32'hFFFF_FFFF);
    add_code(12'd4);

    // long self-referencing chain: strings over two words
    add_code(lzwd_pkg::ClearCode);
    add_code(12'd90);
    for (int i = 0; i < 70; i++) add_code(12'(gen_count - 1));
    wait_idle();

    // random mix
    for (int i = 0; i < 6; i++) begin
      if ($urandom_range(0, 29) == 0) add_code(lzwd_pkg::ClearCode);
      else add_code(pick_code(40));
    end
    wait_idle();
    write_limit(bytes_out[31:0] + 32'd40);
    for (int i = 0; i < 4; i++) add_code(pick_code(40));
    wait_idle();
    write_limit(32'hFFFF_FFFF);

    // final part without idling: a stop or a bad code, then codes that follow it
    calm = 1;
    for (int i = 0; i < 6; i++) add_code(pick_code(40));
    if ($urandom_range(0, 1) == 0 || gen_count >= lzwd_pkg::DictDepth)
      add_code(lzwd_pkg::StopCode);
    else add_code(12'($urandom_range(gen_count, 4095)));
    add_code(12'd0);
    add_code(12'hFFF);
    add_code(lzwd_pkg::ClearCode);

    wait_idle();
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* sim.f */
design/lzwd_pkg.sv
design/lzwd_dict.sv
design/lzwd_strbuf.sv
design/lzw_code_decoder_core.sv
bench/testbench.sv
